[src/ptc_pkg.sv]
package ptc_pkg;

    localparam int FIELD_BITS = 32;
    localparam int TOTAL_BITS = 32;
    localparam int SEEN_BITS  = 2;

    localparam logic [SEEN_BITS-1:0] SEEN_FULL = 2'd2;

    typedef enum logic [2:0] {
        TURN_NONE     = 3'd0,
        TURN_LEFT     = 3'd1,
        TURN_RIGHT    = 3'd2,
        TURN_REVERSAL = 3'd3,
        TURN_STRAIGHT = 3'd4
    } ptc_class_t;

    typedef struct packed {
        logic go;
        logic start;
    } ptc_ctrl_t;

    typedef struct packed {
        logic       start;
        ptc_class_t cls;
    } ptc_result_t;

endpackage

[src/polyline_turn_classifier.sv]
// a result is offered once its input transfer has passed
// through five register stages
// (register, differences, products, sign and class, count update)
// one vertex per cycle while not stalled; only the vertex window and counts feed back
// aresetn (synchronous, active low) empties the pipeline, clears the
// vertex window and zeroes the left, right and reversal counts
module polyline_turn_classifier #(
    parameter int COORD_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_start_path,
    input  logic signed [ptc_pkg::FIELD_BITS-1:0] s_px,
    input  logic signed [ptc_pkg::FIELD_BITS-1:0] s_py,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_turn_class,
    output logic [ptc_pkg::TOTAL_BITS-1:0]       m_left_total,
    output logic [ptc_pkg::TOTAL_BITS-1:0]       m_right_total,
    output logic [ptc_pkg::TOTAL_BITS-1:0]       m_reversal_total
);
    import ptc_pkg::*;

    logic signed [COORD_BITS-1:0] x_in, y_in;
    logic signed [COORD_BITS-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic [SEEN_BITS-1:0]         seen_reg, seen_next;
    ptc_ctrl_t                    ctrl;
    logic                         s_xfer;

    logic        core_valid, core_ready;
    ptc_result_t core_res;

    logic                  out_valid_reg;
    ptc_class_t            out_cls_reg;
    logic [COUNT_BITS-1:0] left_count_reg, right_count_reg, reversal_count_reg;
    logic [COUNT_BITS-1:0] left_next, right_next, reversal_next;
    logic [COUNT_BITS-1:0] left_base, right_base, reversal_base;

    assign x_in   = s_px[COORD_BITS-1:0];
    assign y_in   = s_py[COORD_BITS-1:0];
    assign s_xfer = s_valid && s_ready;

    assign ctrl.start = s_start_path;
    assign ctrl.go    = !s_start_path && (seen_reg == SEEN_FULL);

    always_comb begin
        if (s_start_path) begin
            seen_next = SEEN_BITS'(1);
        end else if (seen_reg == SEEN_FULL) begin
            seen_next = SEEN_FULL;
        end else begin
            seen_next = seen_reg + SEEN_BITS'(1);
        end
    end

    // vertex window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (s_xfer) begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            older_x_reg <= newer_x_reg;
            older_y_reg <= newer_y_reg;
            newer_x_reg <= x_in;
            newer_y_reg <= y_in;
        end
    end

    ptc_turn_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_ctrl  (ctrl),
        .in_x     (x_in),
        .in_y     (y_in),
        .in_ox    (older_x_reg),
        .in_oy    (older_y_reg),
        .in_nx    (newer_x_reg),
        .in_ny    (newer_y_reg),
        .out_valid(core_valid),
        .out_ready(core_ready),
        .out_res  (core_res)
    );

    assign core_ready = !out_valid_reg || m_ready;

    // saturating counters, cleared by a path start
    always_comb begin
        left_base     = core_res.start ? '0 : left_count_reg;
        right_base    = core_res.start ? '0 : right_count_reg;
        reversal_base = core_res.start ? '0 : reversal_count_reg;
        left_next     = left_base;
        right_next    = right_base;
        reversal_next = reversal_base;
        case (core_res.cls)
            TURN_LEFT: begin
                if (left_base != '1) begin
                    left_next = left_base + COUNT_BITS'(1);
                end
            end
            TURN_RIGHT: begin
                if (right_base != '1) begin
                    right_next = right_base + COUNT_BITS'(1);
                end
            end
            TURN_REVERSAL: begin
                if (reversal_base != '1) begin
                    reversal_next = reversal_base + COUNT_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg      <= 1'b0;
            left_count_reg     <= '0;
            right_count_reg    <= '0;
            reversal_count_reg <= '0;
        end else if (core_valid && core_ready) begin
            out_valid_reg      <= 1'b1;
            left_count_reg     <= left_next;
            right_count_reg    <= right_next;
            reversal_count_reg <= reversal_next;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_valid && core_ready) begin
            out_cls_reg <= core_res.cls;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_turn_class     = out_cls_reg;
    assign m_left_total     = TOTAL_BITS'(left_count_reg);
    assign m_right_total    = TOTAL_BITS'(right_count_reg);
    assign m_reversal_total = TOTAL_BITS'(reversal_count_reg);

    a_left_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_cls_reg == TURN_LEFT) |-> left_count_reg != '0)
        else $error("left turn shown with zero left count");

    a_right_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_cls_reg == TURN_RIGHT) |-> right_count_reg != '0)
        else $error("right turn shown with zero right count");

    a_rev_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_cls_reg == TURN_REVERSAL) |-> reversal_count_reg != '0)
        else $error("reversal shown with zero reversal count");

    a_counts_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(left_count_reg)
            && $stable(right_count_reg) && $stable(reversal_count_reg))
        else $error("counts changed while result stalled");

endmodule

[src/ptc_turn_core.sv]
module ptc_turn_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ptc_pkg::ptc_ctrl_t           in_ctrl,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_ox,
    input  logic signed [COORD_BITS-1:0] in_oy,
    input  logic signed [COORD_BITS-1:0] in_nx,
    input  logic signed [COORD_BITS-1:0] in_ny,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ptc_pkg::ptc_result_t         out_res
);
    import ptc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    ptc_ctrl_t c1_reg, c2_reg, c3_reg;
    ptc_result_t res4_reg;

    logic signed [COORD_BITS-1:0] x1_reg, y1_reg, ox1_reg, oy1_reg, nx1_reg, ny1_reg;
    logic signed [DW-1:0] x_e, y_e, ox_e, oy_e, nx_e, ny_e;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PW:0]   cross_sum, dot1, dot2;
    logic                 rev;
    ptc_class_t           cls_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid = v4_reg;
    assign out_res   = res4_reg;

    // sign extension to difference width
    assign x_e  = {x1_reg[COORD_BITS-1], x1_reg};
    assign y_e  = {y1_reg[COORD_BITS-1], y1_reg};
    assign ox_e = {ox1_reg[COORD_BITS-1], ox1_reg};
    assign oy_e = {oy1_reg[COORD_BITS-1], oy1_reg};
    assign nx_e = {nx1_reg[COORD_BITS-1], nx1_reg};
    assign ny_e = {ny1_reg[COORD_BITS-1], ny1_reg};

    // exact cross and dot sums
    assign cross_sum = {p0_reg[PW-1], p0_reg} - {p1_reg[PW-1], p1_reg};
    assign dot1      = {p2_reg[PW-1], p2_reg} + {p3_reg[PW-1], p3_reg};
    assign dot2      = {p4_reg[PW-1], p4_reg} + {p5_reg[PW-1], p5_reg};
    assign rev       = dot1[PW] || (dot1 == '0) || dot2[PW] || (dot2 == '0);

    always_comb begin
        if (!c3_reg.go) begin
            cls_next = TURN_NONE;
        end else if (cross_sum[PW]) begin
            cls_next = TURN_RIGHT;
        end else if (cross_sum != '0) begin
            cls_next = TURN_LEFT;
        end else if (rev) begin
            cls_next = TURN_REVERSAL;
        end else begin
            cls_next = TURN_STRAIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            c1_reg  <= in_ctrl;
            x1_reg  <= in_x;
            y1_reg  <= in_y;
            ox1_reg <= in_ox;
            oy1_reg <= in_oy;
            nx1_reg <= in_nx;
            ny1_reg <= in_ny;
        end
        if (rdy2 && v1_reg) begin
            c2_reg <= c1_reg;
            ax_reg <= x_e - nx_e;
            ay_reg <= y_e - ny_e;
            bx_reg <= ox_e - nx_e;
            by_reg <= oy_e - ny_e;
            ex_reg <= x_e - ox_e;
            ey_reg <= y_e - oy_e;
            fx_reg <= ox_e - x_e;
            fy_reg <= oy_e - y_e;
        end
        if (rdy3 && v2_reg) begin
            c3_reg <= c2_reg;
            p0_reg <= ax_reg * by_reg;
            p1_reg <= ay_reg * bx_reg;
            p2_reg <= ex_reg * ax_reg;
            p3_reg <= ey_reg * ay_reg;
            p4_reg <= bx_reg * fx_reg;
            p5_reg <= by_reg * fy_reg;
        end
        if (rdy4 && v3_reg) begin
            res4_reg.start <= c3_reg.start;
            res4_reg.cls   <= cls_next;
        end
    end

endmodule

[tb/sv/polyline_turn_classifier_tb.sv]
`timescale 1ns / 100ps

module polyline_turn_classifier_tb;

    import ptc_pkg::*;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        ptc_class_t  cls;
        logic [31:0] left_n;
        logic [31:0] right_n;
        logic [31:0] rev_n;
    } turn_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_start_path = 1'b0;
    logic signed [31:0]       s_px = '0;
    logic signed [31:0]       s_py = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [2:0]               m_turn_class;
    logic [31:0]              m_left_total;
    logic [31:0]              m_right_total;
    logic [31:0]              m_reversal_total;

    bit                       sender_gaps = 1'b1;
    bit                       receiver_stalls = 1'b1;
    int                       error_count = 0;
    turn_result_t             expected_turns[$];

    // vertex window and running counts of the current path
    logic signed [31:0]       far_x = '0, far_y = '0, near_x = '0, near_y = '0;
    int unsigned              path_pts = 0;
    logic [31:0]              lefts = '0, rights = '0, reversals = '0;

    polyline_turn_classifier u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_path     (s_start_path),
        .s_px             (s_px),
        .s_py             (s_py),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_turn_class     (m_turn_class),
        .m_left_total     (m_left_total),
        .m_right_total    (m_right_total),
        .m_reversal_total (m_reversal_total)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("polyline_turn_classifier: mismatch");
        $finish;
    end

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // o on segment a..b, given the three points are collinear
    function automatic bit on_segment(input logic signed [31:0] ax, ay, bx, by, ox, oy);
        logic signed [67:0] ux, uy, vx, vy, dot;
        ux = ox - ax;
        uy = oy - ay;
        vx = ox - bx;
        vy = oy - by;
        dot = ux * vx + uy * vy;
        return dot <= 0;
    endfunction

    function automatic turn_result_t classify_vertex(input logic start,
                                                     input logic signed [31:0] x, y);
        turn_result_t       r;
        logic signed [67:0] ax, ay, bx, by, cross_val;
        r.cls = TURN_NONE;
        if (start) begin
            far_x = '0;
            far_y = '0;
            near_x = '0;
            near_y = '0;
            path_pts = 0;
            lefts = '0;
            rights = '0;
            reversals = '0;
        end
        if (path_pts >= 2) begin
            ax = x - near_x;
            ay = y - near_y;
            bx = far_x - near_x;
            by = far_y - near_y;
            cross_val = ax * by - ay * bx;
            if (cross_val < 0) begin
                r.cls = TURN_RIGHT;
                rights = bump(rights);
            end else if (cross_val > 0) begin
                r.cls = TURN_LEFT;
                lefts = bump(lefts);
            end else if (on_segment(far_x, far_y, near_x, near_y, x, y) ||
                         on_segment(near_x, near_y, x, y, far_x, far_y)) begin
                r.cls = TURN_REVERSAL;
                reversals = bump(reversals);
            end else begin
                r.cls = TURN_STRAIGHT;
            end
        end else begin
            path_pts++;
        end
        far_x = near_x;
        far_y = near_y;
        near_x = x;
        near_y = y;
        r.left_n = lefts;
        r.right_n = rights;
        r.rev_n = reversals;
        return r;
    endfunction

    task automatic report_error(input string what, input logic [31:0] got, want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // expectation formed on each input transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_turns.insert(expected_turns.size(),
                                  classify_vertex(s_start_path, s_px, s_py));
        end
    end

    always @(posedge aclk) begin
        turn_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_turns.size() == 0) begin
                report_error("unexpected result, turn_class", m_turn_class, 0);
            end else begin
                want = expected_turns.pop_front();
                if (m_turn_class !== want.cls)
                    report_error("turn_class", m_turn_class, want.cls);
                if (m_left_total !== want.left_n)
                    report_error("left_total", m_left_total, want.left_n);
                if (m_right_total !== want.right_n)
                    report_error("right_total", m_right_total, want.right_n);
                if (m_reversal_total !== want.rev_n)
                    report_error("reversal_total", m_reversal_total, want.rev_n);
            end
        end
    end

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = receiver_stalls ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic push_vertex(input logic start, input logic signed [31:0] x, y);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_path <= start;
        s_px <= x;
        s_py <= y;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_turns.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return COORD_MAX - 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // stream begins without a start flag
    task automatic test_no_start_path();
        push_vertex(1'b0, 0, 0);
        push_vertex(1'b0, 4, 0);
        push_vertex(1'b0, 4, 4);
        push_vertex(1'b0, 0, 4);
    endtask

    task automatic test_turn_kinds();
        push_vertex(1'b1, 0, 0);
        push_vertex(1'b0, 2, 0);
        push_vertex(1'b0, 2, -2);
        push_vertex(1'b0, 2, -5);
        // doubling back onto the last segment
        push_vertex(1'b0, 2, -3);
        // coincident, then all equal
        push_vertex(1'b0, 2, -3);
        push_vertex(1'b0, 2, -3);
        // older vertex lies between the newer one and the next
        push_vertex(1'b1, 2, 0);
        push_vertex(1'b0, 4, 0);
        push_vertex(1'b0, 0, 0);
    endtask

    task automatic test_extremes();
        push_vertex(1'b1, COORD_MIN, COORD_MIN);
        push_vertex(1'b0, COORD_MAX, COORD_MAX);
        push_vertex(1'b0, COORD_MIN, COORD_MIN);
        push_vertex(1'b0, COORD_MIN, COORD_MAX);
        push_vertex(1'b0, COORD_MAX, COORD_MIN);
        push_vertex(1'b0, COORD_MAX - 32'sd1, COORD_MAX);
        push_vertex(1'b0, COORD_MAX, COORD_MAX);
    endtask

    task automatic test_random_paths(input int n_items);
        int sent, path_len, mode, bx, by, dx, dy, k;
        logic signed [31:0] x, y;
        logic start;
        sent = 0;
        while (sent < n_items) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            path_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 40);
            mode = $urandom_range(0, 3);
            bx = $urandom;
            by = $urandom;
            dx = $urandom_range(0, 6) - 3;
            dy = $urandom_range(0, 6) - 3;
            for (int i = 0; i < path_len; i++) begin
                case (mode)
                    0: begin
                        x = $urandom;
                        y = $urandom;
                    end
                    1: begin
                        x = $urandom_range(0, 8) - 4;
                        y = $urandom_range(0, 8) - 4;
                    end
                    2: begin
                        // points along one line
                        k = $urandom_range(0, 10) - 5;
                        x = bx + k * dx;
                        y = by + k * dy;
                    end
                    default: begin
                        x = edge_coord();
                        y = edge_coord();
                    end
                endcase
                // now and then a path carries on without its start flag
                start = (i == 0) ? ($urandom_range(0, 9) != 0)
                                 : ($urandom_range(0, 49) == 0);
                push_vertex(start, x, y);
                sent++;
            end
        end
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_start_path();
        test_turn_kinds();
        test_extremes();
        test_random_paths(370);
        drain_results();
        test_random_paths(370);
        drain_results();
        repeat (12) @(posedge aclk);
        if (expected_turns.size() != 0) begin
            report_error("results missing", expected_turns.size(), 0);
        end
        if (error_count == 0) begin
            $display("polyline_turn_classifier: match");
        end else begin
            $display("polyline_turn_classifier: mismatch");
        end
        $finish;
    end

endmodule
